FILE: design/lcd_seq_pkg.sv
// shared types, timing constants and helpers for the lcd mode/line sequencer
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package lcd_seq_pkg;

  // mode lengths in cpu cycles
  localparam logic [12:0] OAM_LEN    = 13'd80;
  localparam logic [12:0] XFER_LEN   = 13'd291;
  localparam logic [12:0] HBLANK_LEN = 13'd85;
  localparam logic [12:0] VBLANK_LEN = 13'd4560;

  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [8:0] LINE_COUNT    = 9'd154;

  // line = (fc / 456) mod 154, with 456 = 8 * 57 and / 57 as a reciprocal multiply
  localparam int unsigned LINE_PRESHIFT  = 3;
  localparam logic [14:0] LINE_RECIP     = 15'd18397;
  localparam int unsigned LINE_RECIP_SHR = 20;

  // output mode codes
  localparam logic [1:0] MODE_CODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_CODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_CODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_CODE_XFER   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_COMPARE_LINE = 3'd0;
  localparam logic [2:0] CFG_LYC_EN       = 3'd1;
  localparam logic [2:0] CFG_OAM_EN       = 3'd2;
  localparam logic [2:0] CFG_VBLANK_EN    = 3'd3;
  localparam logic [2:0] CFG_HBLANK_EN    = 3'd4;

  typedef enum logic [3:0] {
    ST_HBLANK = 4'b0001,
    ST_VBLANK = 4'b0010,
    ST_OAM    = 4'b0100,
    ST_XFER   = 4'b1000
  } lcd_state_e;

  typedef struct packed {
    logic oam;
    logic vblank;
    logic hblank;
  } mode_irq_en_t;

  typedef struct packed {
    logic        adv;
    lcd_state_e  state;
    logic [12:0] mc;
    logic        stat_req;
    logic        vbl;
    logic        restart;
  } step_res_t;

  function automatic logic [1:0] mode_code(lcd_state_e st);
    logic [1:0] code;
    case (st)
      ST_HBLANK: code = MODE_CODE_HBLANK;
      ST_VBLANK: code = MODE_CODE_VBLANK;
      ST_OAM:    code = MODE_CODE_OAM;
      ST_XFER:   code = MODE_CODE_XFER;
      default:   code = MODE_CODE_OAM;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: design/lcd_mode_line_sequencer_top.sv
// top level of the lcd mode/line sequencer: state, config registers, output register
// depends on lcd_seq_pkg, lcd_seq_line and lcd_seq_step
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   cycles_i
//   out      output     out_valid_o / out_ready_i lcd_mode_o current_line_o coincidence_o
//                                                 stat_irq_o vblank_irq_o frame_done_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// one item per cycle: a tick is fully evaluated in the cycle it is accepted and its
// result lands in the output register on the same edge
// the rate is set by the state update loop (two sequenced mode passes,
// one line-number multiply)
// in_ready_o drops only while the output register holds an item that is not taken
// reset puts the sequencer in oam scan with zero counts and clears all config
// cfg writes are always taken
`default_nettype none

module lcd_mode_line_sequencer_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [6:0] cycles_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      lcd_mode_o,
  output logic [7:0]      current_line_o,
  output logic            coincidence_o,
  output logic            stat_irq_o,
  output logic            vblank_irq_o,
  output logic            frame_done_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  lcd_seq_pkg::lcd_state_e state_q, state_d;
  logic [12:0] mc_q, mc_d;
  logic [16:0] fc_q, fc_d;

  logic [7:0] compare_line_q;
  logic       lyc_en_q;
  lcd_seq_pkg::mode_irq_en_t irq_en_q;

  logic       out_valid_q;
  logic [1:0] mode_q;
  logic [7:0] line_q, line_d;
  logic       coin_q, coin_d;
  logic       stat_q, stat_d;
  logic       vbl_q, vbl_d;

  logic        in_acc;
  logic [12:0] mc0;
  logic [16:0] fc0;
  logic [7:0]  line0, line1, line2;
  logic        match0, match1, match2;
  logic        adv1;
  lcd_seq_pkg::step_res_t res0, res1;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign mc0 = mc_q + {6'b0, cycles_i};
  assign fc0 = fc_q + {10'b0, cycles_i};

  lcd_seq_line u_line (
    .frame_cycles_i (fc0),
    .line_o         (line0)
  );

  lcd_seq_step u_step0 (
    .state_i (state_q),
    .mc_i    (mc0),
    .line_i  (line0),
    .en_i    (irq_en_q),
    .res_o   (res0)
  );

  // after a frame restart the count is a small remainder, so the line is zero
  assign line1 = res0.restart ? 8'd0 : line0;

  lcd_seq_step u_step1 (
    .state_i (res0.state),
    .mc_i    (res0.mc),
    .line_i  (line1),
    .en_i    (irq_en_q),
    .res_o   (res1)
  );

  assign adv1  = res0.adv && res1.adv;
  assign line2 = res1.restart ? 8'd0 : line1;

  assign match0 = lyc_en_q && (line0 == compare_line_q);
  assign match1 = lyc_en_q && (line1 == compare_line_q);
  assign match2 = lyc_en_q && (line2 == compare_line_q);

  always_comb begin
    if (adv1) begin
      state_d = res1.state;
      mc_d    = res1.mc;
      line_d  = line2;
      coin_d  = match2;
    end else if (res0.adv) begin
      state_d = res0.state;
      mc_d    = res0.mc;
      line_d  = line1;
      coin_d  = match1;
    end else begin
      state_d = state_q;
      mc_d    = mc0;
      line_d  = line0;
      coin_d  = match0;
    end

    if (adv1 && res1.restart) begin
      fc_d = {4'b0, res1.mc};
    end else if (res0.restart) begin
      fc_d = {4'b0, res0.mc};
    end else begin
      fc_d = fc0;
    end

    // line match counts in every pass, mode entries only when taken
    stat_d = match0 || res0.stat_req || (res0.adv && match1)
             || (adv1 && (res1.stat_req || match2));
    vbl_d  = res0.vbl || (adv1 && res1.vbl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcd_seq_pkg::ST_OAM;
      mc_q    <= '0;
      fc_q    <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
      mc_q    <= mc_d;
      fc_q    <= fc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compare_line_q <= '0;
      lyc_en_q       <= 1'b0;
      irq_en_q       <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lcd_seq_pkg::CFG_COMPARE_LINE: compare_line_q  <= cfg_data_i;
        lcd_seq_pkg::CFG_LYC_EN:       lyc_en_q        <= cfg_data_i[0];
        lcd_seq_pkg::CFG_OAM_EN:       irq_en_q.oam    <= cfg_data_i[0];
        lcd_seq_pkg::CFG_VBLANK_EN:    irq_en_q.vblank <= cfg_data_i[0];
        lcd_seq_pkg::CFG_HBLANK_EN:    irq_en_q.hblank <= cfg_data_i[0];
        default: begin
          compare_line_q <= compare_line_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= lcd_seq_pkg::mode_code(state_d);
      line_q <= line_d;
      coin_q <= coin_d;
      stat_q <= stat_d;
      vbl_q  <= vbl_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lcd_mode_o     = mode_q;
  assign current_line_o = line_q;
  assign coincidence_o  = coin_q;
  assign stat_irq_o     = stat_q;
  assign vblank_irq_o   = vbl_q;
  assign frame_done_o   = vbl_q;

  // remainder stays below the length of the current mode, so two passes suffice
  a_mc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != lcd_seq_pkg::ST_OAM)    || (mc_q < lcd_seq_pkg::OAM_LEN)) &&
    ((state_q != lcd_seq_pkg::ST_XFER)   || (mc_q < lcd_seq_pkg::XFER_LEN)) &&
    ((state_q != lcd_seq_pkg::ST_HBLANK) || (mc_q < lcd_seq_pkg::HBLANK_LEN)) &&
    ((state_q != lcd_seq_pkg::ST_VBLANK) || (mc_q < lcd_seq_pkg::VBLANK_LEN)))
    else $error("mode remainder out of range");

  a_no_third_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && adv1 |-> (res1.state == lcd_seq_pkg::ST_XFER)
                       || (res1.state == lcd_seq_pkg::ST_OAM)
                       || (res1.state == lcd_seq_pkg::ST_VBLANK))
    else $error("unexpected second mode change");

  a_vbl_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && vbl_d |=> lcd_mode_o == lcd_seq_pkg::MODE_CODE_VBLANK)
    else $error("vblank request without vblank mode");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted tick produced no result");

endmodule

`default_nettype wire

FILE: design/lcd_seq_line.sv
// line number from the frame cycle count: (fc / 456) mod 154
// depends on lcd_seq_pkg for the reciprocal constants
`default_nettype none

module lcd_seq_line (
  input  wire logic [16:0] frame_cycles_i,
  output logic      [7:0]  line_o
);

  logic [13:0] pre;
  logic [28:0] prod;
  logic [8:0]  quot;

  assign pre  = frame_cycles_i[16:lcd_seq_pkg::LINE_PRESHIFT];
  // exact floor(pre / 57) over the whole 14-bit range
  assign prod = 29'(pre) * 29'(lcd_seq_pkg::LINE_RECIP);
  assign quot = prod[28:lcd_seq_pkg::LINE_RECIP_SHR];

  // quotient stays below 2 * 154, so one subtract does the modulo
  always_comb begin
    if (quot >= lcd_seq_pkg::LINE_COUNT) begin
      line_o = 8'(quot - lcd_seq_pkg::LINE_COUNT);
    end else begin
      line_o = quot[7:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/lcd_seq_step.sv
// one evaluation pass of the mode sequence: at most one mode change
// depends on lcd_seq_pkg for states, lengths and the result struct
`default_nettype none

module lcd_seq_step (
  input  wire lcd_seq_pkg::lcd_state_e   state_i,
  input  wire logic [12:0]               mc_i,
  input  wire logic [7:0]                line_i,
  input  wire lcd_seq_pkg::mode_irq_en_t en_i,
  output lcd_seq_pkg::step_res_t         res_o
);

  always_comb begin
    res_o          = '0;
    res_o.state    = state_i;
    res_o.mc       = mc_i;
    case (state_i)
      lcd_seq_pkg::ST_OAM: begin
        if (mc_i >= lcd_seq_pkg::OAM_LEN) begin
          res_o.adv   = 1'b1;
          res_o.mc    = mc_i - lcd_seq_pkg::OAM_LEN;
          res_o.state = lcd_seq_pkg::ST_XFER;
        end
      end
      lcd_seq_pkg::ST_XFER: begin
        if (mc_i >= lcd_seq_pkg::XFER_LEN) begin
          res_o.adv      = 1'b1;
          res_o.mc       = mc_i - lcd_seq_pkg::XFER_LEN;
          res_o.state    = lcd_seq_pkg::ST_HBLANK;
          res_o.stat_req = en_i.hblank;
        end
      end
      lcd_seq_pkg::ST_HBLANK: begin
        if (mc_i >= lcd_seq_pkg::HBLANK_LEN) begin
          res_o.adv = 1'b1;
          res_o.mc  = mc_i - lcd_seq_pkg::HBLANK_LEN;
          if (line_i < lcd_seq_pkg::VISIBLE_LINES) begin
            res_o.state    = lcd_seq_pkg::ST_OAM;
            res_o.stat_req = en_i.oam;
          end else begin
            res_o.state    = lcd_seq_pkg::ST_VBLANK;
            res_o.vbl      = 1'b1;
            res_o.stat_req = en_i.vblank;
          end
        end
      end
      lcd_seq_pkg::ST_VBLANK: begin
        if (mc_i >= lcd_seq_pkg::VBLANK_LEN) begin
          res_o.adv      = 1'b1;
          res_o.mc       = mc_i - lcd_seq_pkg::VBLANK_LEN;
          res_o.state    = lcd_seq_pkg::ST_OAM;
          res_o.stat_req = en_i.oam;
          // new frame count starts from the leftover remainder
          res_o.restart  = 1'b1;
        end
      end
      default: begin
        res_o.adv = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for lcd_mode_line_sequencer_top: random cpu ticks against a
// cycle-exact timing predictor, with register changes between idle phases
// depends on lcd_seq_pkg and the rtl of the block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DOTS_PER_LINE = 456;
  localparam int          RANDOM_TICKS  = 830;
  localparam int          PHASE_TICKS   = 120;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line;
    logic       coincidence;
    logic       stat_irq;
    logic       vblank_irq;
    logic       frame_done;
  } lcd_status_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       tick_valid  = 1'b0;
  logic [6:0] tick_cycles = '0;
  logic       res_ready   = 1'b0;
  logic       reg_valid   = 1'b0;
  logic [2:0] reg_index   = '0;
  logic [7:0] reg_data    = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] lcd_mode_o;
  logic [7:0] current_line_o;
  logic       coincidence_o;
  logic       stat_irq_o;
  logic       vblank_irq_o;
  logic       frame_done_o;
  logic       cfg_ready_o;

  // shadow registers and sequencer state
  logic [7:0]  cmp_line = '0;
  logic        lyc_en   = 1'b0;
  logic        oam_en   = 1'b0;
  logic        vbl_en   = 1'b0;
  logic        hbl_en   = 1'b0;
  logic [12:0] mode_cnt  = '0;
  logic [16:0] frame_cnt = '0;
  logic [1:0]  lcd_mode_now = lcd_seq_pkg::MODE_CODE_OAM;

  logic [6:0]  queued_ticks[$];
  lcd_status_t predicted_status[$];

  int ticks_queued   = 0;
  int ticks_taken    = 0;
  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  lcd_mode_line_sequencer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (tick_valid),
    .in_ready_o     (in_ready_o),
    .cycles_i       (tick_cycles),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (res_ready),
    .lcd_mode_o     (lcd_mode_o),
    .current_line_o (current_line_o),
    .coincidence_o  (coincidence_o),
    .stat_irq_o     (stat_irq_o),
    .vblank_irq_o   (vblank_irq_o),
    .frame_done_o   (frame_done_o),
    .cfg_valid_i    (reg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (reg_index),
    .cfg_data_i     (reg_data)
  );

  always #10 clk_i = ~clk_i;

  // runs one tick through the mode sequence, one pass per mode change plus a last pass
  task automatic advance_lcd_timing(input logic [6:0] cyc);
    lcd_status_t st;
    logic [7:0]  line;
    logic        settled;
    st = '0;
    line = '0;
    settled = 1'b0;
    mode_cnt = mode_cnt + 13'(cyc);
    frame_cnt = frame_cnt + 17'(cyc);
    while (!settled) begin
      line = 8'((frame_cnt / DOTS_PER_LINE) % lcd_seq_pkg::LINE_COUNT);
      st.coincidence = lyc_en && (line == cmp_line);
      if (st.coincidence) st.stat_irq = 1'b1;
      case (lcd_mode_now)
        lcd_seq_pkg::MODE_CODE_OAM: begin
          if (mode_cnt >= lcd_seq_pkg::OAM_LEN) begin
            mode_cnt = mode_cnt - lcd_seq_pkg::OAM_LEN;
            lcd_mode_now = lcd_seq_pkg::MODE_CODE_XFER;
          end else begin
            settled = 1'b1;
          end
        end
        lcd_seq_pkg::MODE_CODE_XFER: begin
          if (mode_cnt >= lcd_seq_pkg::XFER_LEN) begin
            mode_cnt = mode_cnt - lcd_seq_pkg::XFER_LEN;
            lcd_mode_now = lcd_seq_pkg::MODE_CODE_HBLANK;
            if (hbl_en) st.stat_irq = 1'b1;
          end else begin
            settled = 1'b1;
          end
        end
        lcd_seq_pkg::MODE_CODE_HBLANK: begin
          if (mode_cnt >= lcd_seq_pkg::HBLANK_LEN) begin
            mode_cnt = mode_cnt - lcd_seq_pkg::HBLANK_LEN;
            if (line < lcd_seq_pkg::VISIBLE_LINES) begin
              lcd_mode_now = lcd_seq_pkg::MODE_CODE_OAM;
              if (oam_en) st.stat_irq = 1'b1;
            end else begin
              lcd_mode_now = lcd_seq_pkg::MODE_CODE_VBLANK;
              st.vblank_irq = 1'b1;
              if (vbl_en) st.stat_irq = 1'b1;
            end
          end else begin
            settled = 1'b1;
          end
        end
        default: begin
          if (mode_cnt >= lcd_seq_pkg::VBLANK_LEN) begin
            mode_cnt = mode_cnt - lcd_seq_pkg::VBLANK_LEN;
            lcd_mode_now = lcd_seq_pkg::MODE_CODE_OAM;
            if (oam_en) st.stat_irq = 1'b1;
            // new frame counts from the leftover
            frame_cnt = 17'(mode_cnt);
          end else begin
            settled = 1'b1;
          end
        end
      endcase
    end
    st.mode = lcd_mode_now;
    st.line = line;
    st.frame_done = st.vblank_irq;
    predicted_status.push_back(st);
  endtask

  task automatic log_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // tick driver
  always @(posedge clk_i) begin : tick_feeder
    logic took;
    took = tick_valid && in_ready_o;
    if (took) begin
      advance_lcd_timing(tick_cycles);
      ticks_taken++;
    end
    if (!tick_valid || took) begin
      if (rst_ni && queued_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tick_valid  <= 1'b1;
        tick_cycles <= queued_ticks.pop_front();
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : status_checker
    lcd_status_t want;
    if (rst_ni && out_valid_o && res_ready) begin
      if (predicted_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result item with nothing predicted, mode %0d line %0d",
                   $realtime, lcd_mode_o, current_line_o);
      end else begin
        want = predicted_status.pop_front();
        if (want.mode != lcd_mode_o) log_mismatch("lcd_mode", want.mode, lcd_mode_o);
        if (want.line != current_line_o)
          log_mismatch("current_line", want.line, current_line_o);
        if (want.coincidence != coincidence_o)
          log_mismatch("coincidence", want.coincidence, coincidence_o);
        if (want.stat_irq != stat_irq_o) log_mismatch("stat_irq", want.stat_irq, stat_irq_o);
        if (want.vblank_irq != vblank_irq_o)
          log_mismatch("vblank_irq", want.vblank_irq, vblank_irq_o);
        if (want.frame_done != frame_done_o)
          log_mismatch("frame_done", want.frame_done, frame_done_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    reg_valid <= 1'b1;
    reg_index <= idx;
    reg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_valid <= 1'b0;
    case (idx)
      lcd_seq_pkg::CFG_COMPARE_LINE: cmp_line = data;
      lcd_seq_pkg::CFG_LYC_EN:       lyc_en = data[0];
      lcd_seq_pkg::CFG_OAM_EN:       oam_en = data[0];
      lcd_seq_pkg::CFG_VBLANK_EN:    vbl_en = data[0];
      lcd_seq_pkg::CFG_HBLANK_EN:    hbl_en = data[0];
      default: ;
    endcase
  endtask

  // enables carry random upper bits, which the block must mask off
  task automatic program_registers(input logic [7:0] line_sel, input logic [3:0] en);
    write_reg(lcd_seq_pkg::CFG_COMPARE_LINE, line_sel);
    write_reg(lcd_seq_pkg::CFG_LYC_EN, {7'($urandom), en[0]});
    write_reg(lcd_seq_pkg::CFG_OAM_EN, {7'($urandom), en[1]});
    write_reg(lcd_seq_pkg::CFG_VBLANK_EN, {7'($urandom), en[2]});
    write_reg(lcd_seq_pkg::CFG_HBLANK_EN, {7'($urandom), en[3]});
  endtask

  task automatic queue_tick(input logic [6:0] cyc);
    while (queued_ticks.size() >= 4) @(posedge clk_i);
    queued_ticks.push_back(cyc);
    ticks_queued++;
  endtask

  // waits until every queued item is taken and its result checked
  task automatic settle();
    while (ticks_taken != ticks_queued || predicted_status.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [6:0] pick_cycles();
    // long ticks dominate so a frame reaches vblank and wraps; ticks past 80 can
    // take two mode changes at once, zero-length ticks pass no time
    if ($urandom_range(3) != 0) return 7'($urandom_range(96, 127));
    return 7'($urandom_range(0, 127));
  endfunction

  initial begin : stimulus
    logic [6:0] directed[$];
    logic [7:0] line_sel;
    logic [7:0] line_now;
    logic [3:0] en;
    int         phase;
    int         issued;
    directed = '{7'd80, 7'd80, 7'd80, 7'd80, 7'd51, 7'd80, 7'd5, 7'd1, 7'd2, 7'd4,
                 7'd8, 7'd16, 7'd32, 7'd64, 7'd63, 7'd79, 7'd80, 7'd80, 7'd80, 7'd80};
    phase = 0;
    issued = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // exact mode boundaries from reset, line 0 match, all mode entries enabled
    program_registers(8'd0, 4'hF);
    foreach (directed[i]) queue_tick(directed[i]);
    settle();

    while (issued < RANDOM_TICKS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      line_now = 8'((frame_cnt / DOTS_PER_LINE) % lcd_seq_pkg::LINE_COUNT);
      case (phase % 6)
        0: line_sel = 8'd255;
        1: line_sel = 8'd153;
        default: line_sel = 8'((line_now + $urandom_range(0, 12)) % lcd_seq_pkg::LINE_COUNT);
      endcase
      case (phase % 5)
        1: en = 4'h0;
        2: en = 4'hF;
        default: en = 4'($urandom);
      endcase
      program_registers(line_sel, en);
      // indexes past the last register are ignored
      if (phase % 7 == 3)
        write_reg(lcd_seq_pkg::CFG_HBLANK_EN + 3'($urandom_range(1, 3)), 8'($urandom));
      for (int i = 0; i < PHASE_TICKS && issued < RANDOM_TICKS; i++) begin
        if (phase % 4 == 0 && i == 20) hold_asks++;
        queue_tick(pick_cycles());
        issued++;
      end
      settle();
      phase++;
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && predicted_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
